FILE: rtl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants for the min-tracking stack: depth, widths,
// operation and error codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int WORD_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int ENTRY_W     = 2 * WORD_W;

  localparam logic [WORD_W-1:0] INT_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  typedef enum logic [1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_PEEK   = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_RSVD  = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic latch;  // capture an incoming transaction
    logic exec;   // perform the operation on count and top registers
    logic load;   // refill top and min from the read port after a pop
  } cmd_t;

  typedef struct packed {
    logic need_load;  // the pending operation is a pop that leaves entries
  } status_t;

endpackage

FILE: rtl/mss_ctrl.sv
// ----------------------------------------------------------------------------
// mss_ctrl
// Sequencer for one transaction: accept, execute, optional refill, present.
// ----------------------------------------------------------------------------
module mss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mss_pkg::status_t status,
  output mss_pkg::cmd_t    cmd
);
  import mss_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = status.need_load ? ST_LOAD : ST_OUT;
      end
      ST_LOAD: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    cmd.latch = (state == ST_IDLE) && in_valid;
    cmd.exec  = (state == ST_EXEC);
    cmd.load  = (state == ST_LOAD);
  end

endmodule

FILE: rtl/mss_dpath.sv
// ----------------------------------------------------------------------------
// mss_dpath
// Entry store, entry count and cached top/min registers of the stack.
// ----------------------------------------------------------------------------
module mss_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  mss_pkg::cmd_t              cmd,
  output mss_pkg::status_t           status,
  input  logic [1:0]                 func,
  input  logic [mss_pkg::WORD_W-1:0] value,
  output logic [mss_pkg::WORD_W-1:0] top_value,
  output logic [mss_pkg::WORD_W-1:0] min_value,
  output logic                       is_empty,
  output logic [1:0]                 error_code
);
  import mss_pkg::*;

  // Each entry holds {running minimum, value}.
  logic [ENTRY_W-1:0] mem [STACK_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [ADDR_W-1:0]  rd_addr;

  func_t                    op_func;
  logic signed [WORD_W-1:0] op_value;
  logic [CNT_W-1:0]         count;
  logic signed [WORD_W-1:0] cur_top;
  logic signed [WORD_W-1:0] cur_min;
  err_t                     err;

  logic                     is_full;
  logic                     is_zero;
  logic signed [WORD_W-1:0] push_min;

  assign is_full = (count == CNT_W'(STACK_DEPTH));
  assign is_zero = (count == '0);

  // Keep the older minimum when it is strictly less than the new value.
  assign push_min = (!is_zero && (cur_min < op_value)) ? cur_min : op_value;

  // After a pop the new top sits two below the current count.
  assign rd_addr = ADDR_W'(count - CNT_W'(2));

  assign status.need_load = (op_func == FUNC_POP) && (count > CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_func  <= func_t'(func);
      op_value <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (op_func == FUNC_PUSH) && !is_full) begin
      mem[count[ADDR_W-1:0]] <= {push_min, op_value};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err   <= ERR_OK;
    end else if (cmd.exec) begin
      unique case (op_func)
        FUNC_PUSH: begin
          if (is_full) begin
            err <= ERR_FULL;
          end else begin
            err     <= ERR_OK;
            count   <= count + CNT_W'(1);
            cur_top <= op_value;
            cur_min <= push_min;
          end
        end
        FUNC_POP: begin
          if (is_zero) begin
            err <= ERR_EMPTY;
          end else begin
            err   <= ERR_OK;
            count <= count - CNT_W'(1);
          end
        end
        FUNC_PEEK, FUNC_UNUSED: begin
          err <= ERR_OK;
        end
        default: begin
          err <= ERR_OK;
        end
      endcase
    end else if (cmd.load) begin
      cur_top <= rd_data[WORD_W-1:0];
      cur_min <= rd_data[ENTRY_W-1:WORD_W];
    end
  end

  assign is_empty   = is_zero;
  assign top_value  = is_zero ? '0 : cur_top;
  assign min_value  = is_zero ? INT_MAX : cur_min;
  assign error_code = err;

endmodule

FILE: rtl/min_stack_shadow.sv
// ----------------------------------------------------------------------------
// min_stack_shadow
// LIFO of signed 32-bit words that also reports the least stored word.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one transaction per operation. s_axis_tuser holds
//   the operation (push, pop, peek; the fourth code acts as a peek) and
//   s_axis_tdata the signed word to push, ignored otherwise.
//   Output stream (m_axis): exactly one transaction per input transaction,
//   carrying the top and minimum after the operation, the empty flag and an
//   error code (push onto a full stack, pop from an empty one). An empty
//   stack reports top 0 and minimum 0x7FFFFFFF.
//   The result is valid once the execute state is done for a push, a peek or
//   a pop that empties the stack or fails; a pop that leaves entries also
//   passes through a refill state, since the new top comes back through the
//   registered read port of the entry store.
//   One operation at a time: no new input is taken until the result of the
//   last one has been taken, and s_axis_tready is high only while the
//   block is idle.
//   Stall: with m_axis_tready low the result holds steady and no new input
//   is taken.
//   Reset: rst (synchronous) empties the stack and returns to idle; the
//   entry store itself is not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
module min_stack_shadow (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] top_value, [63:32] min_value
  output logic [2:0]  m_axis_tuser    // [0] is_empty, [2:1] error_code
);
  import mss_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [WORD_W-1:0] top_value;
  logic [WORD_W-1:0] min_value;
  logic              is_empty;
  logic [1:0]        error_code;

  // Sequence each transaction through accept, execute, refill when needed and present.
  mss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the entries, the count and the cached top and minimum.
  mss_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .func       (s_axis_tuser),
    .value      (s_axis_tdata),
    .top_value  (top_value),
    .min_value  (min_value),
    .is_empty   (is_empty),
    .error_code (error_code)
  );

  // Result registers sit in the datapath and stay put until the next execute.
  assign m_axis_tdata = {min_value, top_value};
  assign m_axis_tuser = {error_code, is_empty};

endmodule

FILE: rtl/mss_checker.sv
// ----------------------------------------------------------------------------
// mss_checker
// Port-level checks on the min-tracking stack, bound to the top level.
// ----------------------------------------------------------------------------
module mss_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import mss_pkg::*;

  // One transaction in flight: never ready for input while a result waits.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  // No result directly after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Empty stack reports the fixed top and minimum.
  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[31:0] == '0) && (m_axis_tdata[63:32] == INT_MAX))
    else $error("empty stack reports wrong top or minimum");

  // Reserved error code never appears, and a failed pop means empty.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[2:1] != ERR_RSVD) &&
      ((m_axis_tuser[2:1] != ERR_EMPTY) || m_axis_tuser[0]))
    else $error("bad error code");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind min_stack_shadow mss_checker u_mss_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/min_stack_shadow_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_stack_shadow_tb
// Self-checking bench for the min-tracking stack. A scoreboard keeps its own
// stack of words and running minima, predicts the top, minimum, empty flag
// and error code of every accepted operation, and compares each returned
// transaction against the oldest prediction. Stimulus opens with directed
// edge cases, then runs random push-heavy, pop-heavy and balanced phases that
// fill and drain the stack repeatedly. Both stream sides idle at random, and
// one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module min_stack_shadow_tb;
  import mss_pkg::*;

  localparam int N_RANDOM    = 1650;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 20;
  localparam int PRINT_CAP   = 40;

  localparam logic [31:0] INT_MIN = 32'h8000_0000;

  // One result transaction, field by field.
  typedef struct packed {
    logic [31:0] top;
    logic [31:0] least;
    logic        empty;
    err_t        err;
  } stack_view_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow stack plus the queue of predicted results
  // --------------------------------------------------------------------------
  class min_stack_scoreboard;
    logic [31:0] word_store  [STACK_DEPTH];
    logic [31:0] least_store [STACK_DEPTH];
    int unsigned fill;
    stack_view_t pending_views[$];
    int          errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    task report_mismatch(input string msg);
      if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Apply one accepted operation to the shadow stack and queue its result.
    function void note_input(input func_t op, input logic [31:0] word);
      stack_view_t view;
      logic [31:0] running;
      view.err = ERR_OK;
      case (op)
        FUNC_PUSH: begin
          if (fill >= STACK_DEPTH) begin
            view.err = ERR_FULL;
          end else begin
            running = word;
            if (fill > 0 && $signed(least_store[fill-1]) < $signed(word))
              running = least_store[fill-1];
            word_store[fill]  = word;
            least_store[fill] = running;
            fill++;
          end
        end
        FUNC_POP: begin
          if (fill == 0) view.err = ERR_EMPTY;
          else fill--;
        end
        default: ;  // peek and the unused code change nothing
      endcase
      if (fill > 0) begin
        view.top   = word_store[fill-1];
        view.least = least_store[fill-1];
        view.empty = 1'b0;
      end else begin
        view.top   = '0;
        view.least = INT_MAX;
        view.empty = 1'b1;
      end
      pending_views.insert(pending_views.size(), view);
    endfunction

    task check_result(input stack_view_t got);
      stack_view_t want;
      if (pending_views.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: %h", got));
      end else begin
        want = pending_views.pop_front();
        if (got.top !== want.top)
          report_mismatch($sformatf("top_value got %h, want %h", got.top, want.top));
        if (got.least !== want.least)
          report_mismatch($sformatf("min_value got %h, want %h", got.least, want.least));
        if (got.empty !== want.empty)
          report_mismatch($sformatf("is_empty got %b, want %b", got.empty, want.empty));
        if (got.err !== want.err)
          report_mismatch($sformatf("error_code got %0d, want %0d", got.err, want.err));
      end
    endtask

    function int outstanding();
      return pending_views.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] value
  logic [1:0]  s_axis_tuser = '0;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [31:0] top_value, [63:32] min_value
  logic [2:0]  m_axis_tuser;        // [0] is_empty, [2:1] error_code

  // Traffic shaping shared by the sender and receiver processes.
  logic quiet_window = 1'b0;  // both sides run without idles
  logic hold_request = 1'b0;  // receiver holds off for a long stretch
  int   cycle_count  = 0;

  min_stack_scoreboard sb = new();

  always #5 clk = ~clk;

  min_stack_shadow dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // --------------------------------------------------------------------------
  // Sender: offer one operation, idle at random first, wait for the transaction
  // --------------------------------------------------------------------------
  // Entered and left at a falling edge, so inputs only move there.
  task send_op(input func_t op, input logic [31:0] word);
    while (!quiet_window && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_input(op, word);
    @(negedge clk);
  endtask

  // Mix extremes, tiny values (to force ties on the minimum) and full-range words.
  function logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return INT_MAX;
      1:       return INT_MIN;
      2:       return 32'd0;
      3:       return 32'($urandom_range(20)) - 32'd10;
      default: return $urandom();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: drive tready at the falling edge
  // --------------------------------------------------------------------------
  initial begin
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        // Hold off long enough that the sender sits stalled behind the pending result.
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      m_axis_tready <= quiet_window || ($urandom_range(99) >= 28);
    end
  end

  // Check every result transaction at the rising edge.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result({m_axis_tdata[31:0], m_axis_tdata[63:32],
                       m_axis_tuser[0], err_t'(m_axis_tuser[2:1])});
  end

  // Watchdog: end the run if the stream hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("min_stack_shadow_tb NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int          phase_left;
    int          push_pct;
    int          roll;
    func_t       op;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty-stack behavior, the unused code, extreme words, drain
    // past the bottom.
    send_op(FUNC_PEEK,   $urandom());
    send_op(FUNC_POP,    $urandom());   // pop refused, stack empty
    send_op(FUNC_UNUSED, $urandom());   // unused code acts as a peek
    send_op(FUNC_PUSH,   INT_MAX);
    send_op(FUNC_PEEK,   32'd0);
    send_op(FUNC_PUSH,   INT_MIN);
    send_op(FUNC_PUSH,   32'd0);
    send_op(FUNC_PUSH,   32'hFFFF_FFFF);
    send_op(FUNC_PUSH,   32'd1);
    send_op(FUNC_PUSH,   32'h5555_5555);
    send_op(FUNC_PUSH,   32'hAAAA_AAAA);
    send_op(FUNC_UNUSED, 32'hFFFF_FFFF);
    repeat (7) send_op(FUNC_POP, $urandom());
    send_op(FUNC_POP,    32'hFFFF_FFFF); // one pop past empty
    send_op(FUNC_PUSH,   32'h7FFF_FFFE);
    send_op(FUNC_PUSH,   INT_MAX);
    send_op(FUNC_POP,    32'd0);
    send_op(FUNC_POP,    32'd0);

    // Random: phases biased toward push or pop, or balanced, so the stack fills
    // to the top (refused pushes) and drains to the bottom (refused pops) many times.
    phase_left = 0;
    push_pct   = 50;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(100, 200);
        case ($urandom_range(2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      phase_left--;
      if (n == 400) hold_request = 1'b1;
      quiet_window = (n >= 700 && n < 1000);
      roll = $urandom_range(99);
      if (roll < push_pct)    op = FUNC_PUSH;
      else if (roll < 92)     op = FUNC_POP;
      else if (roll < 96)     op = FUNC_PEEK;
      else                    op = FUNC_UNUSED;
      send_op(op, pick_word());
    end
    s_axis_tvalid <= 1'b0;
    quiet_window = 1'b0;

    // Drain: wait for every predicted result, then idle on to catch anything extra.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.errors == 0) begin
      $display("min_stack_shadow_tb OK");
    end else begin
      $display("min_stack_shadow_tb NOT OK");
    end
    $finish;
  end

endmodule
